>>> rtl/lrutd_pkg.sv
// lrutd_pkg: shared types and constants of the lru tag directory
package lrutd_pkg;

    localparam int KEY_W  = 64;
    localparam int AGE_W  = 14;
    localparam int SLOT_W = 4;
    // index width that covers up to 64 entries; m_slot carries only the low SLOT_W bits of it
    localparam int IDX_W  = 6;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // search token that walks down the row of cells, one cell per cycle
    typedef struct packed {
        logic             active;
        logic             mode;
        logic [KEY_W-1:0] key;
        logic             found;     // key match (lookup) or empty slot (insert)
        logic [IDX_W-1:0] hit_idx;
        logic [AGE_W-1:0] best_age;
        logic [IDX_W-1:0] best_idx;
    } carry_t;

    // update broadcast to every cell at the end of a scan
    typedef struct packed {
        logic             active;    // touch the selected entry
        logic             write;     // store key and set valid
        logic [IDX_W-1:0] sel;
        logic [KEY_W-1:0] key;
    } upd_t;

endpackage

>>> rtl/lrutd_cell.sv
// lrutd_cell: one directory entry plus one stage of the search chain
module lrutd_cell #(
    parameter int IDX     = 0,
    parameter int AGE_TOP = 9999
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  lrutd_pkg::carry_t carry_in,
    output lrutd_pkg::carry_t carry_out,
    input  lrutd_pkg::upd_t   upd
);
    import lrutd_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [AGE_W-1:0] TOP    = AGE_W'(AGE_TOP);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AGE_W-1:0] age_reg;
    carry_t           carry_reg;
    carry_t           carry_next;
    logic             mine;

    always_comb begin
        carry_next = carry_in;
        if (carry_in.active) begin
            if (carry_in.mode == MODE_INSERT) begin
                if (!carry_in.found && !valid_reg) begin
                    carry_next.found   = 1'b1;
                    carry_next.hit_idx = MY_IDX;
                end
                // strict compare keeps the lowest index on ties
                if (age_reg < carry_in.best_age) begin
                    carry_next.best_age = age_reg;
                    carry_next.best_idx = MY_IDX;
                end
            end else begin
                if (!carry_in.found && valid_reg && (key_reg == carry_in.key)) begin
                    carry_next.found   = 1'b1;
                    carry_next.hit_idx = MY_IDX;
                end
            end
        end
    end

    assign mine = (upd.sel == MY_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg.active <= 1'b0;
        end else begin
            carry_reg.active <= carry_next.active;
        end
        carry_reg.mode     <= carry_next.mode;
        carry_reg.key      <= carry_next.key;
        carry_reg.found    <= carry_next.found;
        carry_reg.hit_idx  <= carry_next.hit_idx;
        carry_reg.best_age <= carry_next.best_age;
        carry_reg.best_idx <= carry_next.best_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end else if (upd.active) begin
            if (mine) begin
                age_reg <= TOP;
                if (upd.write) begin
                    valid_reg <= 1'b1;
                end
            end else if (valid_reg && (age_reg != '0)) begin
                age_reg <= age_reg - AGE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.active && upd.write && mine) begin
            key_reg <= upd.key;
        end
    end

    assign carry_out = carry_reg;

endmodule

>>> rtl/lrutd_ctrl.sv
// lrutd_ctrl: request sequencing, end-of-scan update and result register
module lrutd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [lrutd_pkg::KEY_W-1:0] s_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [lrutd_pkg::SLOT_W-1:0] m_slot,
    output logic                        m_evicted,
    output lrutd_pkg::carry_t           carry_first,
    input  lrutd_pkg::carry_t           carry_last,
    output lrutd_pkg::upd_t             upd
);
    import lrutd_pkg::*;

    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_evicted_reg;
    logic              res_hit_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_evicted_reg;
    logic              finish;
    logic              out_free;
    logic              is_insert;
    logic [IDX_W-1:0]  sel;

    assign finish    = carry_last.active;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_insert = (carry_last.mode == MODE_INSERT);
    assign sel       = (is_insert && !carry_last.found) ? carry_last.best_idx
                                                        : carry_last.hit_idx;

    always_comb begin
        s_ready     = 1'b0;
        state_next  = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        carry_first.active   = s_valid && s_ready;
        carry_first.mode     = s_mode;
        carry_first.key      = s_key;
        carry_first.found    = 1'b0;
        carry_first.hit_idx  = '0;
        carry_first.best_age = '1;
        carry_first.best_idx = '0;
    end

    // lookup miss leaves the state alone; inserts always write and touch
    always_comb begin
        upd.active = finish && (is_insert || carry_last.found);
        upd.write  = finish && is_insert;
        upd.sel    = sel;
        upd.key    = carry_last.key;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            res_hit_reg     <= !is_insert && carry_last.found;
            res_slot_reg    <= (is_insert || carry_last.found) ? sel[SLOT_W-1:0] : '0;
            res_evicted_reg <= is_insert && !carry_last.found;
        end
        if (state_reg == ST_HOLD && out_free) begin
            m_hit_reg     <= res_hit_reg;
            m_slot_reg    <= res_slot_reg;
            m_evicted_reg <= res_evicted_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_slot    = m_slot_reg;
    assign m_evicted = m_evicted_reg;

    a_finish_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        carry_last.active |-> state_reg == ST_SCAN)
        else $error("scan token left the chain outside a scan");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_SCAN)
        else $error("accepted request did not start a scan");

    a_hold_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("held result not moved to the output register");

endmodule

>>> rtl/lru_tag_directory_top.sv
// lru_tag_directory_top: fully associative lru tag directory built as a row of entry cells
//
//  channel | direction | fields                      | handshake
//  s_      | in        | s_mode, s_key               | s_valid / s_ready
//  m_      | out       | m_hit, m_slot, m_evicted    | m_valid / m_ready
//
// a request runs from accept to m_valid in order: the search token walks the row of cells
// one entry per cycle, the update and the result registers take it from the last cell, then
// the result waits in the hold state until the output register is free.
// one request is in the directory at a time; s_ready is high only when no scan runs,
// so the next request is taken only once the last result has moved to the output register.
// a waiting result in the output register does not block the next request.
// reset clears the valid bits and ages at once; no clearing pass is needed.
module lru_tag_directory_top #(
    parameter int ENTRIES = 16,
    parameter int AGE_TOP = 9999
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [lrutd_pkg::KEY_W-1:0]  s_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [lrutd_pkg::SLOT_W-1:0] m_slot,
    output logic                         m_evicted
);
    import lrutd_pkg::*;

    carry_t             carry_first;
    carry_t             chain [ENTRIES];
    upd_t               upd;
    logic [ENTRIES-1:0] token_vec;

    lrutd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_slot      (m_slot),
        .m_evicted   (m_evicted),
        .carry_first (carry_first),
        .carry_last  (chain[ENTRIES-1]),
        .upd         (upd)
    );

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        carry_t cin;
        if (i == 0) begin : g_head
            assign cin = carry_first;
        end else begin : g_link
            assign cin = chain[i-1];
        end
        lrutd_cell #(
            .IDX     (i),
            .AGE_TOP (AGE_TOP)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .carry_in  (cin),
            .carry_out (chain[i]),
            .upd       (upd)
        );
        assign token_vec[i] = chain[i].active;
    end

    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(token_vec))
        else $error("more than one search token in the cell row");

endmodule

>>> sim/lru_tag_directory_chk.sv
// lru_tag_directory_chk: tracks requests into the lru tag directory and checks every result
module lru_tag_directory_chk #(
    parameter int ENTRIES = 16,
    parameter int AGE_TOP = 9999
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_mode,
    input  logic [lrutd_pkg::KEY_W-1:0]  s_key,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_hit,
    input  logic [lrutd_pkg::SLOT_W-1:0] m_slot,
    input  logic                         m_evicted,
    output int                           fail_count,
    output int                           pending
);
    import lrutd_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } dir_result_t;

    typedef struct {
        int          req_num;
        dir_result_t res;
    } outcome_t;

    logic             slot_used [ENTRIES];
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [AGE_W-1:0] slot_age  [ENTRIES];
    outcome_t         dir_outcomes [$];
    int               req_count;

    initial begin
        fail_count = 0;
        pending    = 0;
        req_count  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    // selected slot becomes newest, every other valid slot gets one step older
    function automatic void refresh_ages(input int sel);
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (i == sel)
                slot_age[i] = AGE_W'(AGE_TOP);
            else if (slot_used[i] && slot_age[i] != '0)
                slot_age[i] = slot_age[i] - AGE_W'(1);
        end
    endfunction

    function automatic dir_result_t resolve_request(input logic mode, input logic [KEY_W-1:0] key);
        dir_result_t res;
        int          sel;
        int          i;
        logic        found;
        res   = '0;
        sel   = 0;
        found = 1'b0;
        if (mode == MODE_LOOKUP) begin
            for (i = 0; i < ENTRIES && !found; i++) begin
                if (slot_used[i] && slot_key[i] == key) begin
                    sel   = i;
                    found = 1'b1;
                end
            end
            // a miss leaves the directory untouched
            if (found) begin
                refresh_ages(sel);
                res.hit  = 1'b1;
                res.slot = sel[SLOT_W-1:0];
            end
        end else begin
            for (i = 0; i < ENTRIES && !found; i++) begin
                if (!slot_used[i]) begin
                    sel   = i;
                    found = 1'b1;
                end
            end
            // directory full: oldest slot, lowest index on ties
            if (!found) begin
                for (i = 1; i < ENTRIES; i++)
                    if (slot_age[i] < slot_age[sel])
                        sel = i;
            end
            slot_key[sel]  = key;
            slot_used[sel] = 1'b1;
            refresh_ages(sel);
            res.slot    = sel[SLOT_W-1:0];
            res.evicted = !found;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t fresh;
        outcome_t head;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_age[i]  = '0;
            end
            dir_outcomes.delete();
        end else begin
            if (s_valid && s_ready) begin
                fresh.req_num = req_count;
                fresh.res     = resolve_request(s_mode, s_key);
                dir_outcomes.push_back(fresh);
                req_count++;
            end
            if (m_valid && m_ready) begin
                if (dir_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result hit=%0d slot=%0d evicted=%0d with no request open",
                                              m_hit, m_slot, m_evicted));
                end else begin
                    head = dir_outcomes.pop_front();
                    if (m_hit !== head.res.hit)
                        report_mismatch($sformatf("request %0d hit=%0d, predicted %0d",
                                                  head.req_num, m_hit, head.res.hit));
                    if (m_slot !== head.res.slot)
                        report_mismatch($sformatf("request %0d slot=%0d, predicted %0d",
                                                  head.req_num, m_slot, head.res.slot));
                    if (m_evicted !== head.res.evicted)
                        report_mismatch($sformatf("request %0d evicted=%0d, predicted %0d",
                                                  head.req_num, m_evicted, head.res.evicted));
                end
            end
        end
        pending <= dir_outcomes.size();
    end

endmodule

>>> sim/lru_tag_directory_top_tb.sv
// lru_tag_directory_top_tb: request traffic and verdict for the lru tag directory
module lru_tag_directory_top_tb;
    import lrutd_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int AGE_TOP      = 9999;
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_REQS   = 400;
    localparam int SAT_LOOKUPS  = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic              s_mode    = MODE_LOOKUP;
    logic [KEY_W-1:0]  s_key     = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic              m_hit;
    logic [SLOT_W-1:0] m_slot;
    logic              m_evicted;

    int               fail_count;
    int               pending;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    logic             long_hold      = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    lru_tag_directory_top #(
        .ENTRIES (ENTRIES),
        .AGE_TOP (AGE_TOP)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_key     (s_key),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .m_slot    (m_slot),
        .m_evicted (m_evicted)
    );

    lru_tag_directory_chk #(
        .ENTRIES (ENTRIES),
        .AGE_TOP (AGE_TOP)
    ) i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_key      (s_key),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_slot     (m_slot),
        .m_evicted  (m_evicted),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin : receiver
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, ENTRIES + 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        // let the open count take in the request accepted at this edge
        @(posedge aclk);
        while (pending != 0 && guard < DRAIN_CYCLES) begin
            @(posedge aclk);
            guard++;
        end
        repeat (ENTRIES + 4) @(posedge aclk);
    endtask

    task automatic directed_requests();
        int i;
        send_request(MODE_LOOKUP, '0);                      // empty directory
        send_request(MODE_INSERT, '0);
        send_request(MODE_INSERT, '1);
        send_request(MODE_INSERT, '1);                      // duplicate key stored again
        send_request(MODE_LOOKUP, '1);                      // two copies, lowest slot reported
        send_request(MODE_LOOKUP, '0);
        send_request(MODE_LOOKUP, 64'h8000_0000_0000_0001);
        for (i = 0; i < ENTRIES - 3; i++)
            send_request(MODE_INSERT, 64'h1 << (4 * i + 2));
        send_request(MODE_INSERT, 64'h5a5a_a5a5_0f0f_f0f0);  // full, evicts the oldest
        send_request(MODE_LOOKUP, '1);
        send_request(MODE_LOOKUP, 64'h1 << 2);
    endtask

    // one key kept hot while every other age falls, then fresh keys evict the oldest
    task automatic saturate_ages();
        logic [KEY_W-1:0] hot_key;
        logic [KEY_W-1:0] fill_key;
        int               i;
        hot_key = 64'h0123_4567_89ab_cdef;
        send_request(MODE_INSERT, hot_key);
        repeat (SAT_LOOKUPS) send_request(MODE_LOOKUP, hot_key);
        for (i = 0; i < 3; i++) begin
            fill_key = {$urandom, $urandom};
            send_request(MODE_INSERT, fill_key);
            send_request(MODE_LOOKUP, fill_key);
        end
    endtask

    task automatic random_requests(input int count, input int hold_at);
        int n;
        int pick;
        int idx;
        for (n = 0; n < count; n++) begin
            if (n == hold_at)
                long_hold = 1'b1;
            pick = $urandom_range(99);
            idx  = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(99) < 4)
                key_pool[idx] = {$urandom, $urandom};
            if (pick < 50)
                send_request(MODE_LOOKUP, key_pool[idx]);
            else if (pick < 80)
                send_request(MODE_INSERT, key_pool[idx]);
            else if (pick < 90)
                send_request(MODE_LOOKUP, {$urandom, $urandom});
            else
                send_request(MODE_INSERT, {$urandom, $urandom});
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_requests();
        drain_results();
        saturate_ages();
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_requests(PHASE_REQS, 100);
        send_idle_pct  = 48;
        recv_stall_pct = 0;
        random_requests(PHASE_REQS, -1);
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        random_requests(PHASE_REQS, -1);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        random_requests(PHASE_REQS, -1);
        drain_results();

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
